// ===== rtl/core/bpc_pkg.sv =====
// Shared types and constants of the button press classifier.
package bpc_pkg;

    // Default width of the tick counters.
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG_ENABLE = 3'd4;

    // Register reset values.
    localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST  = 16'd20;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST      = 16'd800;
    localparam logic [TICK_W-1:0] VERY_LONG_TICKS_RST = 16'd5000;

    typedef enum logic [1:0] {
        EV_SHORT        = 2'd0,
        EV_LONG         = 2'd1,
        EV_VERY_LONG    = 2'd2,
        EV_VERY_LONG_UP = 2'd3
    } t_event_kind;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] very_long_ticks;
        logic              long_enable;
        logic              very_long_enable;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_event_kind kind;
    } t_event;

endpackage

// ===== rtl/core/bpc_if.sv =====
// Handshake channel interfaces of the button press classifier.
interface bpc_in_if;
    logic valid;
    logic ready;
    logic raw_level;

    modport source (output valid, output raw_level, input ready);
    modport sink   (input valid, input raw_level, output ready);
endinterface

interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;

    modport source (output valid, output event_kind, input ready);
    modport sink   (input valid, input event_kind, output ready);
endinterface

interface bpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/bpc_core.sv =====
// Debounce and hold-time state with the per-tick event decision.
module bpc_core
    import bpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_step,
    input  logic   i_raw,
    input  t_cfg   i_cfg,
    output t_event o_evt
);

    localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;

    logic                  r_last_raw, n_last_raw;
    logic                  r_stable, n_stable;
    logic [COUNT_BITS-1:0] r_since, n_since;
    logic                  r_pressed, n_pressed;
    logic [COUNT_BITS-1:0] r_hold, n_hold;
    logic                  r_long_done, n_long_done;
    logic                  r_vl_done, n_vl_done;

    logic   take_level;
    logic   pressed_now;
    t_event evt;

    always_comb begin
        n_last_raw  = i_raw;
        n_stable    = r_stable;
        n_pressed   = r_pressed;
        n_hold      = r_hold;
        n_long_done = r_long_done;
        n_vl_done   = r_vl_done;
        pressed_now = 1'b0;
        evt.valid   = 1'b0;
        evt.kind    = EV_SHORT;

        // Restart the quiet-time count on any raw edge, saturate otherwise.
        if (i_raw != r_last_raw) begin
            n_since = '0;
        end else if (r_since == '1) begin
            n_since = r_since;
        end else begin
            n_since = r_since + COUNT_BITS'(1);
        end

        take_level = (CMP_W'(n_since) >= CMP_W'(i_cfg.debounce_ticks))
                     && (r_stable != i_raw);

        if (take_level) begin
            n_stable = i_raw;
            if (!i_raw) begin
                n_pressed   = 1'b1;
                pressed_now = 1'b1;
                n_hold      = '0;
            end else if (r_pressed) begin
                if (r_vl_done) begin
                    if (i_cfg.very_long_enable) begin
                        evt.valid = 1'b1;
                        evt.kind  = EV_VERY_LONG_UP;
                    end
                end else if (!r_long_done) begin
                    evt.valid = 1'b1;
                    evt.kind  = EV_SHORT;
                end
            end
            if (i_raw) begin
                n_pressed = 1'b0;
            end
            n_long_done = 1'b0;
            n_vl_done   = 1'b0;
        end

        if (n_pressed) begin
            if (!pressed_now && (r_hold != '1)) begin
                n_hold = r_hold + COUNT_BITS'(1);
            end
            // Very long wins a tie; long may follow on a later tick.
            if (!n_vl_done && i_cfg.very_long_enable &&
                (CMP_W'(n_hold) >= CMP_W'(i_cfg.very_long_ticks))) begin
                n_vl_done = 1'b1;
                evt.valid = 1'b1;
                evt.kind  = EV_VERY_LONG;
            end else if (!n_long_done && i_cfg.long_enable &&
                         (CMP_W'(n_hold) >= CMP_W'(i_cfg.long_ticks))) begin
                n_long_done = 1'b1;
                evt.valid   = 1'b1;
                evt.kind    = EV_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= 1'b1;
            r_stable    <= 1'b1;
            r_since     <= '0;
            r_pressed   <= 1'b0;
            r_hold      <= '0;
            r_long_done <= 1'b0;
            r_vl_done   <= 1'b0;
        end else if (i_step) begin
            r_last_raw  <= n_last_raw;
            r_stable    <= n_stable;
            r_since     <= n_since;
            r_pressed   <= n_pressed;
            r_hold      <= n_hold;
            r_long_done <= n_long_done;
            r_vl_done   <= n_vl_done;
        end
    end

    assign o_evt = evt;

endmodule

// ===== rtl/core/button_press_classifier.sv =====
// Top level of the button press classifier: channels, registers and result stage.
//
// Each request on i_in is one millisecond tick carrying the raw, active-low button
// pin. The block debounces the pin, times the hold and returns at most one event
// per tick on o_out: short press, long press, very long press or very long release.
// Ticks that cause no event return nothing. The block takes one tick per clock
// cycle: a tick lands in the input register, and when it advances the classifier
// state and the result register update together. The only limit on rate is the
// one-deep result register; while a shown event is not taken the input stage
// holds and stalls the source. Configuration writes on i_cfg are always taken and
// are meant for idle periods.
module button_press_classifier
    import bpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bpc_in_if.sink     i_in,
    bpc_out_if.source  o_out,
    bpc_cfg_if.sink    i_cfg
);

    // Configuration registers.
    t_cfg r_cfg;

    // Input stage.
    logic r_in_valid;
    logic r_in_raw;

    // Result stage.
    logic        r_out_valid;
    t_event_kind r_out_kind;

    logic   advance;
    t_event evt;

    // Move a held tick into the classifier when the result slot is free or draining.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= DEBOUNCE_TICKS_RST;
            r_cfg.long_ticks       <= LONG_TICKS_RST;
            r_cfg.very_long_ticks  <= VERY_LONG_TICKS_RST;
            r_cfg.long_enable      <= 1'b1;
            r_cfg.very_long_enable <= 1'b1;
        end else if (i_cfg.valid) begin
            // Drop writes to indexes past the register list.
            unique case (i_cfg.index)
                REG_DEBOUNCE_TICKS:   r_cfg.debounce_ticks   <= i_cfg.wdata;
                REG_LONG_TICKS:       r_cfg.long_ticks       <= i_cfg.wdata;
                REG_VERY_LONG_TICKS:  r_cfg.very_long_ticks  <= i_cfg.wdata;
                REG_LONG_ENABLE:      r_cfg.long_enable      <= i_cfg.wdata[0];
                REG_VERY_LONG_ENABLE: r_cfg.very_long_enable <= i_cfg.wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Capture a tick whenever the input stage is free or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_raw <= i_in.raw_level;
        end
    end

    bpc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_raw   (r_in_raw),
        .i_cfg   (r_cfg),
        .o_evt   (evt)
    );

    // Clear the result slot once taken; load it when a tick yields an event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && evt.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && evt.valid) begin
            r_out_kind <= evt.kind;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_out_kind;

    // A new event never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && evt.valid) |-> (!r_out_valid || o_out.ready))
        else $error("event would overwrite a pending result");

    // An empty input stage always takes a request.
    a_in_free_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input stage empty but not ready");

    // Long events only fire while long detection is enabled.
    a_long_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && evt.valid && (evt.kind == EV_LONG)) |-> r_cfg.long_enable)
        else $error("long event while long detection is disabled");

    // Very long events only fire while very long detection is enabled.
    a_very_long_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && evt.valid &&
         ((evt.kind == EV_VERY_LONG) || (evt.kind == EV_VERY_LONG_UP)))
        |-> r_cfg.very_long_enable)
        else $error("very long event while very long detection is disabled");

endmodule
